>>> rtl/idad_pkg.sv
// Shared types, constants and tables of the interleaved delta audio decoder.
`timescale 1ns / 1ps

package idad_pkg;

    localparam int QF      = 47;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int ROM_N   = 128;

    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_NIBBLE = 1'b1;

    localparam logic REG_DECODE_MODE   = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    localparam logic [3:0] NIB_SKIP = 4'hF;

    typedef logic [15:0] t_rom [0:ROM_N-1];

    typedef struct packed {
        logic        mode;
        logic [2:0]  ch;
        logic [2:0]  cm1;
        logic        nz;
        logic [16:0] d1;
        logic [16:0] d2;
        logic        close;
        logic        fin;
        logic        pad;
        logic [2:0]  pad_start;
    } t_item;

    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[QF+63:QF];
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] dv;
        logic [63:0] rnd;
        num = 64'd230258509299404568;
        den = 64'd2812574042515172000;
        y   = 64'd0;
        for (int i = 0; i < QF; i++) begin
            num = num << 1;
            y   = y << 1;
            if (num >= den) begin
                num = num - den;
                y   = y | 64'd1;
            end
        end
        term = 64'd1 << QF;
        r    = term;
        for (int i = 1; i <= 24; i++) begin
            term = mul_q(term, y);
            dv   = 64'(i);
            rem  = 64'd0;
            q    = 64'd0;
            for (int k = 63; k >= 0; k--) begin
                rem = {rem[62:0], term[k]};
                if (rem >= dv) begin
                    rem  = rem - dv;
                    q[k] = 1'b1;
                end
            end
            term = q;
            r    = r + term;
        end
        p = 64'd1 << QF;
        for (int i = 0; i < ROM_N; i++) begin
            p      = mul_q(p, r);
            rnd    = p + (64'd1 << (QF - 1));
            rom[i] = rnd[QF+15:QF];
        end
        return rom;
    endfunction

    localparam t_rom LOG_ROM = build_rom();

    function automatic logic [16:0] nib_step(input logic [3:0] code);
        logic [16:0] s;
        unique case (code)
            4'd0:    s = -17'sd8192;
            4'd1:    s = -17'sd4096;
            4'd2:    s = -17'sd2048;
            4'd3:    s = -17'sd1024;
            4'd4:    s = -17'sd512;
            4'd5:    s = -17'sd256;
            4'd6:    s = -17'sd64;
            4'd7:    s = 17'sd0;
            4'd8:    s = 17'sd64;
            4'd9:    s = 17'sd256;
            4'd10:   s = 17'sd512;
            4'd11:   s = 17'sd1024;
            4'd12:   s = 17'sd2048;
            4'd13:   s = 17'sd4096;
            4'd14:   s = 17'sd8192;
            default: s = 17'sd0;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [32:0] v);
        logic [15:0] s;
        if (v > 33'sd32767) begin
            s = 16'h7FFF;
        end else if (v < -33'sd32768) begin
            s = 16'h8000;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [32:0] v);
        logic [31:0] s;
        if (v > 33'sd2147483647) begin
            s = 32'h7FFF_FFFF;
        end else if (v < -33'sd2147483648) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

endpackage

>>> rtl/idad_front.sv
// Front end: accepts code bytes, assigns channels and frame flags, looks up deltas.
`timescale 1ns / 1ps

module idad_front #(
    parameter int NCH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_decode_mode,
    input  logic [3:0]          i_channel_count,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // code_byte
    input  logic                i_s_tlast,   // stream_end
    output logic                o_push,
    input  logic                i_q_ready,
    output idad_pkg::t_item     o_item
);

    logic [2:0]  r_pos;
    logic [2:0]  n_pos;
    logic [2:0]  w_cm1;
    logic [2:0]  w_ch;
    logic        w_last_ch;
    logic        w_close;
    logic        w_accept;
    logic [6:0]  w_idx;
    logic [15:0] w_rom;
    logic [16:0] w_mag;

    always_comb begin
        if (i_channel_count == 4'd0) begin
            w_cm1 = 3'd0;
        end else if (i_channel_count > 4'(NCH)) begin
            w_cm1 = 3'(NCH - 1);
        end else begin
            w_cm1 = 3'(i_channel_count - 4'd1);
        end
        w_ch      = (r_pos > w_cm1) ? 3'd0 : r_pos;
        w_last_ch = (w_ch == w_cm1);
        w_close   = w_last_ch || i_s_tlast;
        w_accept  = i_s_tvalid && i_q_ready;
        n_pos     = r_pos;
        if (w_accept) begin
            n_pos = w_close ? 3'd0 : w_ch + 3'd1;
        end

        w_idx = i_s_tdata[7] ? ~i_s_tdata[6:0] : i_s_tdata[6:0] - 7'd1;
        w_rom = idad_pkg::LOG_ROM[w_idx];
        w_mag = {1'b0, w_rom};

        o_item.mode      = i_decode_mode;
        o_item.ch        = w_ch;
        o_item.cm1       = w_cm1;
        o_item.nz        = (i_s_tdata != 8'd0);
        o_item.close     = w_close;
        o_item.fin       = i_s_tlast;
        o_item.pad       = i_s_tlast && !w_last_ch;
        o_item.pad_start = w_ch + 3'd1;
        if (i_decode_mode == idad_pkg::MODE_BYTE) begin
            o_item.d1 = i_s_tdata[7] ? 17'(-w_mag) : w_mag;
            o_item.d2 = 17'd0;
        end else begin
            o_item.d1 = idad_pkg::nib_step(i_s_tdata[7:4]);
            o_item.d2 = idad_pkg::nib_step(i_s_tdata[3:0]);
        end
    end

    assign o_s_tready = i_q_ready;
    assign o_push     = i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

>>> rtl/idad_queue.sv
// Short queue of classified items between front end and back end.
`timescale 1ns / 1ps

module idad_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  idad_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output idad_pkg::t_item o_item
);

    idad_pkg::t_item           r_mem [idad_pkg::Q_DEPTH];
    logic [idad_pkg::Q_AW-1:0] r_wr;
    logic [idad_pkg::Q_AW-1:0] r_rd;
    logic [idad_pkg::Q_AW:0]   r_cnt;
    logic [idad_pkg::Q_AW-1:0] n_wr;
    logic [idad_pkg::Q_AW-1:0] n_rd;
    logic [idad_pkg::Q_AW:0]   n_cnt;
    logic                      w_do_push;
    logic                      w_do_pop;

    always_comb begin
        o_ready   = (r_cnt != (idad_pkg::Q_AW + 1)'(idad_pkg::Q_DEPTH));
        o_valid   = (r_cnt != '0);
        o_item    = r_mem[r_rd];
        w_do_push = i_push && o_ready;
        w_do_pop  = i_pop && o_valid;
        n_wr      = w_do_push ? r_wr + (idad_pkg::Q_AW)'(1) : r_wr;
        n_rd      = w_do_pop ? r_rd + (idad_pkg::Q_AW)'(1) : r_rd;
        n_cnt     = r_cnt;
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + (idad_pkg::Q_AW + 1)'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - (idad_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/idad_back.sv
// Back end: applies deltas to channel accumulators and emits samples, padding and held rows.
`timescale 1ns / 1ps

module idad_back #(
    parameter int NCH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  idad_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [23:0]     o_m_tdata,   // sample[15:0], channel[18:16], zeros
    output logic            o_m_tlast    // run_last
);

    localparam int IW = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_PAD  = 2'd2;
    localparam logic [1:0] S_ROW  = 2'd3;

    logic [31:0] r_acc  [NCH];
    logic [15:0] r_pend [NCH];
    logic [NCH-1:0] r_lvalid;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    idad_pkg::t_item r_ent;
    idad_pkg::t_item n_ent;
    logic [31:0]     r_a;
    logic [31:0]     n_a;
    logic            r_row;
    logic            n_row;
    logic [2:0]      r_i;
    logic [2:0]      n_i;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [15:0]     r_out_sample;
    logic [2:0]      r_out_chan;
    logic            r_out_last;

    logic            w_out_ok;
    logic            w_emit;
    logic [15:0]     w_sample;
    logic [2:0]      w_chan;
    logic            w_last;
    logic            w_i_end;
    logic [31:0]     w_acc_rd;
    logic [32:0]     w_sum1;
    logic [31:0]     w_a1;
    logic [32:0]     w_sum2;
    logic [31:0]     w_a2;
    logic            w_any;
    logic            w_lo_wr;
    logic            w_acc_any;

    always_comb begin
        w_out_ok = !r_out_valid || i_m_tready;
        w_acc_rd = r_acc[i_item.ch[IW-1:0]];
        w_sum1   = $signed({w_acc_rd[31], w_acc_rd}) + $signed({{16{i_item.d1[16]}}, i_item.d1});
        if (i_item.mode == idad_pkg::MODE_BYTE) begin
            if (i_item.nz) begin
                w_a1 = 32'($signed(idad_pkg::sat16(w_sum1)));
            end else begin
                w_a1 = w_acc_rd;
            end
        end else begin
            w_a1 = idad_pkg::sat32(w_sum1);
        end
        w_sum2 = $signed({r_a[31], r_a}) + $signed({{16{r_ent.d2[16]}}, r_ent.d2});
        w_a2   = idad_pkg::sat32(w_sum2);

        w_any = 1'b0;
        for (int k = 0; k < NCH; k++) begin
            if (r_lvalid[k] && (3'(k) <= i_item.cm1)) begin
                w_any = 1'b1;
            end
        end
        w_acc_any = 1'b0;
        for (int k = 0; k < NCH; k++) begin
            if (r_acc[k] != 32'd0) begin
                w_acc_any = 1'b1;
            end
        end

        o_pop    = 1'b0;
        w_emit   = 1'b0;
        w_sample = 16'd0;
        w_chan   = r_i;
        w_last   = 1'b0;
        w_lo_wr  = 1'b0;
        w_i_end  = (r_i == r_ent.cm1);
        n_state  = r_state;
        n_ent    = r_ent;
        n_a      = r_a;
        n_row    = r_row;
        n_i      = r_i;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_ent   = i_item;
                    n_a     = w_a1;
                    n_row   = i_item.close && ((i_item.mode == idad_pkg::MODE_NIBBLE) || w_any);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_emit   = w_out_ok;
                w_sample = idad_pkg::sat16({r_a[31], r_a});
                w_chan   = r_ent.ch;
                w_last   = !r_ent.pad && !r_row;
                w_lo_wr  = w_out_ok && (r_ent.mode == idad_pkg::MODE_NIBBLE);
                if (w_out_ok) begin
                    if (r_ent.pad) begin
                        n_i     = r_ent.pad_start;
                        n_state = S_PAD;
                    end else if (r_row) begin
                        n_i     = 3'd0;
                        n_state = S_ROW;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                w_emit = w_out_ok;
                w_last = w_i_end && !r_row;
                if (w_out_ok) begin
                    if (!w_i_end) begin
                        n_i = r_i + 3'd1;
                    end else if (r_row) begin
                        n_i     = 3'd0;
                        n_state = S_ROW;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ROW: begin
                w_emit   = w_out_ok;
                w_sample = r_lvalid[r_i[IW-1:0]] ? r_pend[r_i[IW-1:0]] : 16'd0;
                w_last   = w_i_end;
                if (w_out_ok) begin
                    if (w_i_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = w_emit ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCH; k++) begin
                r_acc[k] <= 32'd0;
            end
            r_lvalid <= '0;
        end else begin
            if (o_pop) begin
                r_acc[i_item.ch[IW-1:0]] <= w_a1;
            end
            if (w_lo_wr) begin
                r_acc[r_ent.ch[IW-1:0]]  <= w_a2;
                r_lvalid[r_ent.ch[IW-1:0]] <= 1'b1;
            end
            if (w_emit && w_last && r_ent.close) begin
                r_lvalid <= '0;
            end
            if (w_emit && w_last && r_ent.fin) begin
                for (int k = 0; k < NCH; k++) begin
                    r_acc[k] <= 32'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lo_wr) begin
            r_pend[r_ent.ch[IW-1:0]] <= idad_pkg::sat16({w_a2[31], w_a2});
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_a   <= n_a;
        r_row <= n_row;
        r_i   <= n_i;
        if (w_emit) begin
            r_out_sample <= w_sample;
            r_out_chan   <= w_chan;
            r_out_last   <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_chan, r_out_sample};
    assign o_m_tlast  = r_out_last;

    ap_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PAD) || (r_state == S_ROW)) |-> (r_i <= r_ent.cm1))
        else $error("row or pad index beyond channel count");

    ap_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == S_IDLE))
        else $error("back end busy after last result of an item");

    ap_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last && r_ent.fin) |=> !w_acc_any)
        else $error("accumulators not cleared at stream end");

endmodule

>>> rtl/interleaved_delta_audio_decoder.sv
// Top level of the interleaved delta audio decoder: config registers, front end, queue, back end.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: code_byte[7:0]; tlast: stream_end
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: sample[15:0], channel[18:16]; tlast: run_last
//  cfg      | in  | i_cfg_we                     | i_cfg_addr, i_cfg_wdata[3:0]
//
//  An item passes the back end's idle and emit states, plus a step per padding or held-row result
//  when it closes a frame; the single result register, loaded once per cycle unless m_axis stalls, sets this pace.
//  A 4-entry queue lets the front end keep taking bytes while the back end drains a frame.
//  Reset is synchronous: it clears accumulators, held flags and position, and sets byte mode and one channel.
//  A stalled m_axis holds the result register and, through the queue, s_axis_tready.
`timescale 1ns / 1ps

module interleaved_delta_audio_decoder #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // code_byte[7:0]
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sample[15:0], channel[18:16], zeros[23:19]
    output logic        m_axis_tlast,   // run_last
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata
);

    localparam int NCH = (MAX_CHANNELS > 8) ? 8 : MAX_CHANNELS;

    logic            r_decode_mode;
    logic [3:0]      r_channel_count;
    logic            w_push;
    logic            w_q_ready;
    logic            w_q_valid;
    logic            w_pop;
    idad_pkg::t_item w_front_item;
    idad_pkg::t_item w_back_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode   <= idad_pkg::MODE_BYTE;
            r_channel_count <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                idad_pkg::REG_DECODE_MODE:   r_decode_mode   <= i_cfg_wdata[0];
                idad_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    idad_front #(
        .NCH(NCH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_decode_mode   (r_decode_mode),
        .i_channel_count (r_channel_count),
        .i_s_tvalid      (s_axis_tvalid),
        .o_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tlast       (s_axis_tlast),
        .o_push          (w_push),
        .i_q_ready       (w_q_ready),
        .o_item          (w_front_item)
    );

    idad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_item  (w_front_item),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_back_item)
    );

    idad_back #(
        .NCH(NCH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_back_item),
        .o_pop        (w_pop),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast)
    );

endmodule
